FILE: rtl/core/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, codes and helpers of the disk request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

   localparam int MAX_TRACKS_DEF = 4096;
   localparam int FIFO_DEPTH_DEF = 256;

   localparam int TRACK_W     = 12;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 13;
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = 6;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] TRACK_COUNT_RESET = 13'd4096;
   localparam logic [TRACK_W-1:0] START_HEAD_RESET  = 12'd0;

   localparam logic CSR_TRACK_COUNT = 1'b0;
   localparam logic CSR_START_HEAD  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_RESTART = 3'd0,
      OP_REQUEST = 3'd1,
      OP_FCFS    = 3'd2,
      OP_SSTF    = 3'd3,
      OP_LOOK    = 3'd4,
      OP_CLOOK   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      RSEL_SCAN  = 2'd0,
      RSEL_TRACK = 2'd1,
      RSEL_FIFO  = 2'd2,
      RSEL_CAND  = 2'd3
   } map_rsel_type;

   typedef enum logic [1:0] {
      WOP_NONE = 2'd0,
      WOP_ZERO = 2'd1,
      WOP_SET  = 2'd2,
      WOP_CLR  = 2'd3
   } map_wop_type;

   typedef enum logic [1:0] {
      RES_DONE   = 2'd0,
      RES_EMPTY  = 2'd1,
      RES_REJECT = 2'd2,
      RES_SERVED = 2'd3
   } res_sel_type;

   typedef enum logic [3:0] {
      S_CLEAR   = 4'd0,
      S_IDLE    = 4'd1,
      S_DECODE  = 4'd2,
      S_REQ_RD  = 4'd3,
      S_REQ_WR  = 4'd4,
      S_FC_TEST = 4'd5,
      S_FC_MAP  = 4'd6,
      S_FC_CHK  = 4'd7,
      S_SC_RUN  = 4'd8,
      S_SC_TAIL = 4'd9,
      S_SC_PICK = 4'd10,
      S_CL_RD   = 4'd11,
      S_CL_WR   = 4'd12,
      S_FINISH  = 4'd13
   } state_type;

   typedef struct packed {
      logic         load;
      logic         init_regs;
      logic         clr_start;
      logic         scan_start;
      logic         scan_issue;
      logic         fc_pop;
      logic         fc_take;
      logic         pick;
      logic         fifo_push;
      map_rsel_type rsel;
      map_wop_type  wop;
      logic         res_load;
      res_sel_type  res;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            req_bad;
      logic            fifo_empty;
      logic            clr_last;
      logic            scan_last;
      logic            fc_hit;
      logic            pick_found;
      logic            out_free;
   } stat_type;

   function automatic logic [BIT_W-1:0] msb_index(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

   function automatic logic [BIT_W-1:0] lsb_index(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/drs_ram.sv
// ----------------------------------------------------------------------------
// drs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/drs_datapath.sv
// ----------------------------------------------------------------------------
// drs_datapath
// Pending bitmap, order FIFO, head and sweep state, scan and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_datapath #(
   parameter int MAX_TRACKS = drs_pkg::MAX_TRACKS_DEF,
   parameter int FIFO_DEPTH = drs_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire drs_pkg::cmd_type                cmd,
   output drs_pkg::stat_type                    stat,
   input  wire logic [drs_pkg::OP_W-1:0]        req_operation,
   input  wire logic [drs_pkg::TRACK_W-1:0]     req_track,
   input  wire logic [drs_pkg::COUNT_W-1:0]     track_count,
   input  wire logic [drs_pkg::TRACK_W-1:0]     start_head,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [drs_pkg::TRACK_W-1:0]     rsp_served_track,
   output logic      [drs_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int MAP_WORDS = (MAX_TRACKS + drs_pkg::WORD_BITS - 1) / drs_pkg::WORD_BITS;
   localparam int WADDR_W   = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
   localparam int TW        = WADDR_W + drs_pkg::BIT_W;
   localparam int HW        = TW > drs_pkg::TRACK_W ? TW : drs_pkg::TRACK_W;
   localparam int PTR_W     = FIFO_DEPTH > 1 ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W    = $clog2(FIFO_DEPTH + 1);
   localparam int WB        = drs_pkg::WORD_BITS;

   // item registers
   logic [drs_pkg::OP_W-1:0]    op_ff, op_in;
   logic [drs_pkg::TRACK_W-1:0] trk_ff, trk_in;

   // FIFO control
   logic [PTR_W-1:0]  rp_ff, rp_in, wp_ff, wp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // head and direction
   logic [drs_pkg::TRACK_W-1:0] head_ff, head_in;
   logic                        sweep_ff, sweep_in;

   // sweep counters
   logic [WADDR_W-1:0] clr_ff, clr_in, scan_ff, scan_in, pword_ff, pword_in;
   logic               pvalid_ff, pvalid_in;

   // scan results
   logic          has_lo_ff, has_lo_in, has_hi_ff, has_hi_in;
   logic [TW-1:0] lo_ff, lo_in, hi_ff, hi_in, mx_ff, mx_in;
   logic [TW-1:0] cand_ff, cand_in;

   // results
   logic [drs_pkg::TRACK_W-1:0]  res_trk_ff, res_trk_in, out_trk_ff, out_trk_in;
   logic [drs_pkg::STATUS_W-1:0] res_st_ff, res_st_in, out_st_ff, out_st_in;
   logic                         out_vld_ff, out_vld_in;

   // memories
   logic                        map_we, fifo_we;
   logic [WADDR_W-1:0]          map_waddr, map_raddr;
   logic [WB-1:0]               map_wdata, map_rdata;
   logic [drs_pkg::TRACK_W-1:0] fifo_rdata;

   logic [HW-1:0]  trk_x, fifo_x, cand_x, head_x, lo_x, hi_x, pick_x;
   logic [TW-1:0]  trk_t, fifo_t, pick;
   logic [WB-1:0]  le_mask, ge_mask, le_bits, ge_bits;
   logic [HW-1:0]  pword_x, hword_x;
   logic           pick_sweep;

   drs_ram #(.WIDTH(WB), .DEPTH(MAP_WORDS)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   drs_ram #(.WIDTH(drs_pkg::TRACK_W), .DEPTH(FIFO_DEPTH)) u_fifo (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (wp_ff),
      .wr_data (trk_ff),
      .rd_addr (rp_ff),
      .rd_data (fifo_rdata)
   );

   always_comb begin
      trk_x  = HW'(trk_ff);
      trk_t  = trk_x[TW-1:0];
      fifo_x = HW'(fifo_rdata);
      fifo_t = fifo_x[TW-1:0];
      cand_x = HW'(cand_ff);
      head_x = HW'(head_ff);
      lo_x   = HW'(lo_ff);
      hi_x   = HW'(hi_ff);

      // map port selection
      case (cmd.rsel)
         drs_pkg::RSEL_SCAN:  map_raddr = scan_ff;
         drs_pkg::RSEL_TRACK: map_raddr = trk_t[TW-1:drs_pkg::BIT_W];
         drs_pkg::RSEL_FIFO:  map_raddr = fifo_t[TW-1:drs_pkg::BIT_W];
         drs_pkg::RSEL_CAND:  map_raddr = cand_ff[TW-1:drs_pkg::BIT_W];
         default:             map_raddr = scan_ff;
      endcase

      map_we    = 1'b0;
      map_waddr = clr_ff;
      map_wdata = '0;
      case (cmd.wop)
         drs_pkg::WOP_ZERO: begin
            map_we = 1'b1;
         end
         drs_pkg::WOP_SET: begin
            map_we    = 1'b1;
            map_waddr = trk_t[TW-1:drs_pkg::BIT_W];
            map_wdata = map_rdata | (WB'(1) << trk_t[drs_pkg::BIT_W-1:0]);
         end
         drs_pkg::WOP_CLR: begin
            map_we    = 1'b1;
            map_waddr = cand_ff[TW-1:drs_pkg::BIT_W];
            map_wdata = map_rdata & ~(WB'(1) << cand_ff[drs_pkg::BIT_W-1:0]);
         end
         default: begin
            map_we = 1'b0;
         end
      endcase
      fifo_we = cmd.fifo_push;

      // window masks of the word in process against the head
      pword_x = HW'(pword_ff);
      hword_x = head_x >> drs_pkg::BIT_W;
      if (pword_x < hword_x) begin
         le_mask = '1;
         ge_mask = '0;
      end else if (pword_x == hword_x) begin
         le_mask = (WB'(2) << head_ff[drs_pkg::BIT_W-1:0]) - WB'(1);
         ge_mask = ~((WB'(1) << head_ff[drs_pkg::BIT_W-1:0]) - WB'(1));
      end else begin
         le_mask = '0;
         ge_mask = '1;
      end
      le_bits = map_rdata & le_mask;
      ge_bits = map_rdata & ge_mask;

      // service choice
      pick       = lo_ff;
      pick_sweep = sweep_ff;
      case (op_ff)
         drs_pkg::OP_SSTF: begin
            if (!has_lo_ff) pick = hi_ff;
            else if (!has_hi_ff) pick = lo_ff;
            else pick = ((hi_x - head_x) < (head_x - lo_x)) ? hi_ff : lo_ff;
         end
         drs_pkg::OP_LOOK: begin
            if (!has_lo_ff) begin
               pick       = hi_ff;
               pick_sweep = 1'b0;
            end else if (!has_hi_ff) begin
               pick       = lo_ff;
               pick_sweep = 1'b1;
            end else begin
               pick = sweep_ff ? lo_ff : hi_ff;
            end
         end
         default: begin
            pick = has_lo_ff ? lo_ff : mx_ff;
         end
      endcase
      pick_x = HW'(pick);

      stat.op         = op_ff;
      stat.req_bad    = ({1'b0, trk_ff} >= track_count)
                        || ({1'b0, trk_x} >= (HW + 1)'(MAX_TRACKS))
                        || (fill_ff >= FILL_W'(FIFO_DEPTH));
      stat.fifo_empty = (fill_ff == '0);
      stat.clr_last   = (clr_ff == WADDR_W'(MAP_WORDS - 1));
      stat.scan_last  = (scan_ff == WADDR_W'(MAP_WORDS - 1));
      stat.fc_hit     = map_rdata[cand_ff[drs_pkg::BIT_W-1:0]];
      stat.pick_found = has_lo_ff || has_hi_ff;
      stat.out_free   = !out_vld_ff || rsp_ready;
   end

   always_comb begin
      op_in     = op_ff;
      trk_in    = trk_ff;
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      head_in   = head_ff;
      sweep_in  = sweep_ff;
      clr_in    = clr_ff;
      scan_in   = scan_ff;
      pvalid_in = cmd.scan_issue;
      pword_in  = scan_ff;
      has_lo_in = has_lo_ff;
      has_hi_in = has_hi_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mx_in     = mx_ff;
      cand_in   = cand_ff;
      res_trk_in = res_trk_ff;
      res_st_in  = res_st_ff;
      out_trk_in = out_trk_ff;
      out_st_in  = out_st_ff;
      out_vld_in = out_vld_ff;

      if (cmd.load) begin
         op_in  = req_operation;
         trk_in = req_track;
      end
      if (cmd.init_regs) begin
         rp_in    = '0;
         wp_in    = '0;
         fill_in  = '0;
         head_in  = start_head;
         sweep_in = 1'b1;
      end
      if (cmd.clr_start) clr_in = '0;
      else if (cmd.wop == drs_pkg::WOP_ZERO) clr_in = clr_ff + WADDR_W'(1);

      if (cmd.fifo_push) begin
         wp_in   = (wp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
         fill_in = fill_ff + FILL_W'(1);
      end
      if (cmd.fc_pop) begin
         rp_in   = (rp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_ff + PTR_W'(1);
         fill_in = fill_ff - FILL_W'(1);
         cand_in = fifo_t;
      end
      if (cmd.fc_take) head_in = cand_x[drs_pkg::TRACK_W-1:0];

      if (cmd.scan_start) begin
         scan_in   = '0;
         has_lo_in = 1'b0;
         has_hi_in = 1'b0;
      end else if (cmd.scan_issue) begin
         scan_in = scan_ff + WADDR_W'(1);
      end
      if (pvalid_ff) begin
         if (le_bits != '0) begin
            has_lo_in = 1'b1;
            lo_in     = {pword_ff, drs_pkg::msb_index(le_bits)};
         end
         if (!has_hi_ff && ge_bits != '0) begin
            has_hi_in = 1'b1;
            hi_in     = {pword_ff, drs_pkg::lsb_index(ge_bits)};
         end
         if (map_rdata != '0) begin
            mx_in = {pword_ff, drs_pkg::msb_index(map_rdata)};
         end
      end
      if (cmd.pick) begin
         cand_in  = pick;
         head_in  = pick_x[drs_pkg::TRACK_W-1:0];
         sweep_in = pick_sweep;
      end

      if (cmd.res_load) begin
         res_trk_in = '0;
         case (cmd.res)
            drs_pkg::RES_EMPTY:  res_st_in = drs_pkg::STATUS_EMPTY;
            drs_pkg::RES_REJECT: res_st_in = drs_pkg::STATUS_REJECT;
            drs_pkg::RES_SERVED: begin
               res_st_in  = drs_pkg::STATUS_DONE;
               res_trk_in = cand_x[drs_pkg::TRACK_W-1:0];
            end
            default: res_st_in = drs_pkg::STATUS_DONE;
         endcase
      end

      if (cmd.out_load) begin
         out_vld_in = 1'b1;
         out_trk_in = res_trk_ff;
         out_st_in  = res_st_ff;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff      <= '0;
         wp_ff      <= '0;
         fill_ff    <= '0;
         head_ff    <= drs_pkg::START_HEAD_RESET;
         sweep_ff   <= 1'b1;
         clr_ff     <= '0;
         scan_ff    <= '0;
         pvalid_ff  <= 1'b0;
         has_lo_ff  <= 1'b0;
         has_hi_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
         head_ff    <= head_in;
         sweep_ff   <= sweep_in;
         clr_ff     <= clr_in;
         scan_ff    <= scan_in;
         pvalid_ff  <= pvalid_in;
         has_lo_ff  <= has_lo_in;
         has_hi_ff  <= has_hi_in;
         out_vld_ff <= out_vld_in;
      end
      op_ff      <= op_in;
      trk_ff     <= trk_in;
      pword_ff   <= pword_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mx_ff      <= mx_in;
      cand_ff    <= cand_in;
      res_trk_ff <= res_trk_in;
      res_st_ff  <= res_st_in;
      out_trk_ff <= out_trk_in;
      out_st_ff  <= out_st_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_served_track = out_trk_ff;
   assign rsp_status       = out_st_ff;

endmodule

`default_nettype wire

FILE: rtl/core/drs_controller.sv
// ----------------------------------------------------------------------------
// drs_controller
// Sequencer of one item at a time: clearing, request, FCFS and scan services.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire drs_pkg::stat_type stat,
   output drs_pkg::cmd_type       cmd
);

   drs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= drs_pkg::S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rsel  = drs_pkg::RSEL_SCAN;
      cmd.wop   = drs_pkg::WOP_NONE;
      cmd.res   = drs_pkg::RES_DONE;

      case (state_ff)
         drs_pkg::S_CLEAR: begin
            cmd.wop = drs_pkg::WOP_ZERO;
            if (stat.clr_last) state_in = drs_pkg::S_IDLE;
         end
         drs_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = drs_pkg::S_DECODE;
            end
         end
         drs_pkg::S_DECODE: begin
            case (stat.op)
               drs_pkg::OP_RESTART: begin
                  cmd.init_regs = 1'b1;
                  cmd.clr_start = 1'b1;
                  cmd.res_load  = 1'b1;
                  state_in      = drs_pkg::S_FINISH;
               end
               drs_pkg::OP_REQUEST: begin
                  if (stat.req_bad) begin
                     cmd.res_load = 1'b1;
                     cmd.res      = drs_pkg::RES_REJECT;
                     state_in     = drs_pkg::S_FINISH;
                  end else begin
                     state_in = drs_pkg::S_REQ_RD;
                  end
               end
               drs_pkg::OP_FCFS: begin
                  state_in = drs_pkg::S_FC_TEST;
               end
               drs_pkg::OP_SSTF, drs_pkg::OP_LOOK, drs_pkg::OP_CLOOK: begin
                  cmd.scan_start = 1'b1;
                  state_in       = drs_pkg::S_SC_RUN;
               end
               default: begin
                  cmd.res_load = 1'b1;
                  state_in     = drs_pkg::S_FINISH;
               end
            endcase
         end
         drs_pkg::S_REQ_RD: begin
            cmd.rsel = drs_pkg::RSEL_TRACK;
            state_in = drs_pkg::S_REQ_WR;
         end
         drs_pkg::S_REQ_WR: begin
            cmd.wop       = drs_pkg::WOP_SET;
            cmd.fifo_push = 1'b1;
            cmd.res_load  = 1'b1;
            state_in      = drs_pkg::S_FINISH;
         end
         drs_pkg::S_FC_TEST: begin
            if (stat.fifo_empty) begin
               cmd.res_load = 1'b1;
               cmd.res      = drs_pkg::RES_EMPTY;
               state_in     = drs_pkg::S_FINISH;
            end else begin
               state_in = drs_pkg::S_FC_MAP;
            end
         end
         drs_pkg::S_FC_MAP: begin
            cmd.rsel   = drs_pkg::RSEL_FIFO;
            cmd.fc_pop = 1'b1;
            state_in   = drs_pkg::S_FC_CHK;
         end
         drs_pkg::S_FC_CHK: begin
            if (stat.fc_hit) begin
               cmd.wop      = drs_pkg::WOP_CLR;
               cmd.fc_take  = 1'b1;
               cmd.res_load = 1'b1;
               cmd.res      = drs_pkg::RES_SERVED;
               state_in     = drs_pkg::S_FINISH;
            end else begin
               state_in = drs_pkg::S_FC_TEST;
            end
         end
         drs_pkg::S_SC_RUN: begin
            cmd.rsel       = drs_pkg::RSEL_SCAN;
            cmd.scan_issue = 1'b1;
            if (stat.scan_last) state_in = drs_pkg::S_SC_TAIL;
         end
         drs_pkg::S_SC_TAIL: begin
            state_in = drs_pkg::S_SC_PICK;
         end
         drs_pkg::S_SC_PICK: begin
            if (stat.pick_found) begin
               cmd.pick = 1'b1;
               state_in = drs_pkg::S_CL_RD;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res      = drs_pkg::RES_EMPTY;
               state_in     = drs_pkg::S_FINISH;
            end
         end
         drs_pkg::S_CL_RD: begin
            cmd.rsel = drs_pkg::RSEL_CAND;
            state_in = drs_pkg::S_CL_WR;
         end
         drs_pkg::S_CL_WR: begin
            cmd.wop      = drs_pkg::WOP_CLR;
            cmd.res_load = 1'b1;
            cmd.res      = drs_pkg::RES_SERVED;
            state_in     = drs_pkg::S_FINISH;
         end
         drs_pkg::S_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in = (stat.op == drs_pkg::OP_RESTART) ? drs_pkg::S_CLEAR
                                                           : drs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = drs_pkg::S_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/disk_request_scheduler.sv
// Request: bitmap word read, then bit set and FIFO push. FCFS: FIFO pop and bitmap
// check, repeated per skipped entry. SSTF/LOOK/C-LOOK: one bitmap word read per cycle.
// Throughput: one item at a time; next item taken once the result is queued.
// Reset and restart: a clearing pass over every word of the bitmap
// RAM, one word a cycle, with req_ready low; register writes are always taken.
// ----------------------------------------------------------------------------
// disk_request_scheduler
// Track request scheduler with FCFS, SSTF, LOOK and C-LOOK service.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_request_scheduler #(
   parameter int MAX_TRACKS = drs_pkg::MAX_TRACKS_DEF,
   parameter int FIFO_DEPTH = drs_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [drs_pkg::OP_W-1:0]         req_operation,
   input  wire logic [drs_pkg::TRACK_W-1:0]      req_track,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [drs_pkg::TRACK_W-1:0]      rsp_served_track,
   output logic      [drs_pkg::STATUS_W-1:0]     rsp_status,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [drs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [drs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [drs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic [drs_pkg::COUNT_W-1:0] tcount_ff, tcount_in;
   logic [drs_pkg::TRACK_W-1:0] shead_ff, shead_in;
   logic                        csr_wr;
   drs_pkg::cmd_type            cmd;
   drs_pkg::stat_type           stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      tcount_in = tcount_ff;
      shead_in  = shead_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            drs_pkg::CSR_TRACK_COUNT: tcount_in = csr_pwdata[drs_pkg::COUNT_W-1:0];
            drs_pkg::CSR_START_HEAD:  shead_in  = csr_pwdata[drs_pkg::TRACK_W-1:0];
            default: tcount_in = tcount_ff;
         endcase
      end
      case (csr_paddr[2])
         drs_pkg::CSR_TRACK_COUNT: csr_prdata = drs_pkg::CSR_DATA_W'(tcount_ff);
         drs_pkg::CSR_START_HEAD:  csr_prdata = drs_pkg::CSR_DATA_W'(shead_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tcount_ff <= drs_pkg::TRACK_COUNT_RESET;
         shead_ff  <= drs_pkg::START_HEAD_RESET;
      end else begin
         tcount_ff <= tcount_in;
         shead_ff  <= shead_in;
      end
   end

   drs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   drs_datapath #(
      .MAX_TRACKS (MAX_TRACKS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_track        (req_track),
      .track_count      (tcount_ff),
      .start_head       (shead_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_served_track (rsp_served_track),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire
